[hw/rtl/lpcdc_pkg.sv]
// lpcdc_pkg: shared constants for the lpc durbin / cepstrum block
// no dependencies
`timescale 1ns / 1ps

package lpcdc_pkg;

  localparam int MaxOrderDef  = 16;
  localparam int MaxCepDef    = 16;
  localparam int DataWidthDef = 32;
  localparam int FracBits     = 23;

  localparam int RegW    = 5;
  localparam int CfgIdxW = 2;
  localparam int IdxW    = 5;

  localparam logic [CfgIdxW-1:0] CfgLpcOrder = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCepCount = 2'd1;

  localparam logic [RegW-1:0] OrderReset = 5'd12;
  localparam logic [RegW-1:0] CepReset   = 5'd12;

  // counter width that holds max(order, cep count) + 1
  function automatic int cnt_w(input int mo, input int mc);
    int m;
    m = (mo > mc) ? mo : mc;
    return $clog2(m + 2);
  endfunction

endpackage

[hw/rtl/lpcdc_front.sv]
// lpcdc_front: configuration registers and frame classification of lag words
// depends on lpcdc_pkg
`timescale 1ns / 1ps

module lpcdc_front import lpcdc_pkg::*; #(
  parameter int MAX_ORDER  = MaxOrderDef,
  parameter int MAX_CEP    = MaxCepDef,
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int CW         = cnt_w(MaxOrderDef, MaxCepDef),
  parameter int EW         = DataWidthDef + 1 + 3 * cnt_w(MaxOrderDef, MaxCepDef)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] lag_value_i,
  input  logic                  lag_valid_i,
  output logic                  lag_ready_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [RegW-1:0]       cfg_data_i,
  output logic                  push_valid_o,
  output logic [EW-1:0]         push_data_o,
  input  logic                  push_ready_i
);

  localparam int KW = (CW > RegW) ? CW : RegW;

  logic [RegW-1:0] order_q, cep_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   p_c, ncep_c;
  logic            last_c;

  function automatic logic [CW-1:0] clamp(input logic [RegW-1:0] v, input int hi);
    logic [KW-1:0] x;
    x = KW'(v);
    if (x == '0) return CW'(1);
    if (x > KW'(hi)) return CW'(hi);
    return CW'(x);
  endfunction

  assign p_c    = clamp(order_q, MAX_ORDER);
  assign ncep_c = clamp(cep_q, MAX_CEP);
  assign last_c = (cnt_q >= p_c);

  assign cfg_ready_o  = 1'b1;
  assign lag_ready_o  = push_ready_i;
  assign push_valid_o = lag_valid_i;
  assign push_data_o  = {lag_value_i, last_c, cnt_q, p_c, ncep_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      cep_q   <= CepReset;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLpcOrder) order_q <= cfg_data_i;
        else if (cfg_index_i == CfgCepCount) cep_q <= cfg_data_i;
      end
      if (lag_valid_i && push_ready_i) begin
        if (last_c) cnt_q <= '0;
        else cnt_q <= cnt_q + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lpcdc_queue.sv]
// lpcdc_queue: two-entry queue between the front and the compute engine
// depends on lpcdc_pkg
`timescale 1ns / 1ps

module lpcdc_queue import lpcdc_pkg::*; #(
  parameter int EW = DataWidthDef + 1 + 3 * cnt_w(MaxOrderDef, MaxCepDef)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  logic [EW-1:0] wr_data_i,
  output logic          wr_ready_o,
  output logic          rd_valid_o,
  output logic [EW-1:0] rd_data_o,
  input  logic          rd_ready_i
);

  logic [EW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

[hw/rtl/lpcdc_div.sv]
// lpcdc_div: restoring divider, one quotient bit per cycle
// depends on lpcdc_pkg
`timescale 1ns / 1ps

module lpcdc_div import lpcdc_pkg::*; #(
  parameter int DVW = DataWidthDef + FracBits,
  parameter int DSW = DataWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [DSW-1:0] divisor_i,
  output logic           busy_o,
  output logic [DVW-1:0] quo_o
);

  localparam int NW = $clog2(DVW + 1);

  logic [NW-1:0]  cnt_q;
  logic [DSW-1:0] rem_q, den_q;
  logic [DVW-1:0] quo_q;
  logic [DSW:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem_q, quo_q[DVW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= NW'(DVW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_o) begin
      rem_q <= ge ? DSW'(rem_sh - {1'b0, den_q}) : DSW'(rem_sh);
      quo_q <= {quo_q[DVW-2:0], ge};
    end
  end

endmodule

[hw/rtl/lpcdc_back.sv]
// lpcdc_back: durbin recursion and lpc-to-cepstrum recursion on one shared divider
// and two multipliers, with the output register; depends on lpcdc_pkg, lpcdc_div
`timescale 1ns / 1ps

module lpcdc_back import lpcdc_pkg::*; #(
  parameter int MAX_ORDER  = MaxOrderDef,
  parameter int MAX_CEP    = MaxCepDef,
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int CW         = cnt_w(MaxOrderDef, MaxCepDef),
  parameter int EW         = DataWidthDef + 1 + 3 * cnt_w(MaxOrderDef, MaxCepDef)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ent_valid_i,
  input  logic [EW-1:0]         ent_data_i,
  output logic                  ent_ready_o,
  output logic                  coef_valid_o,
  input  logic                  coef_ready_i,
  output logic [IdxW-1:0]       coef_index_o,
  output logic [DATA_WIDTH-1:0] coef_value_o,
  output logic                  bad_error_flag_o,
  output logic                  frame_last_o
);

  localparam int W   = DATA_WIDTH;
  localparam int MW  = W + 1;
  localparam int PW  = 2 * MW;
  localparam int SW  = W + 10;
  localparam int DVW = W + FracBits;
  localparam int AIW = $clog2(MAX_ORDER);
  localparam int RIW = $clog2(MAX_ORDER + 1);
  localparam int CIW = $clog2(MAX_CEP);

  localparam logic signed [W-1:0]  Vmax    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  Vmin    = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0]        VmaxP   = {{(PW-W){1'b0}}, Vmax};
  localparam logic [PW-1:0]        RndBias = PW'(2**(FracBits-1));
  localparam logic signed [MW-1:0] QOne    = MW'(2**FracBits);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_STEP  = 5'd2;
  localparam logic [4:0] S_ACC   = 5'd3;
  localparam logic [4:0] S_ACCM  = 5'd4;
  localparam logic [4:0] S_ACCA  = 5'd5;
  localparam logic [4:0] S_KDIV  = 5'd6;
  localparam logic [4:0] S_KWAIT = 5'd7;
  localparam logic [4:0] S_KKM   = 5'd8;
  localparam logic [4:0] S_KKA   = 5'd9;
  localparam logic [4:0] S_EM    = 5'd10;
  localparam logic [4:0] S_EA    = 5'd11;
  localparam logic [4:0] S_UPD   = 5'd12;
  localparam logic [4:0] S_UPM   = 5'd13;
  localparam logic [4:0] S_UPA   = 5'd14;
  localparam logic [4:0] S_CACC  = 5'd15;
  localparam logic [4:0] S_CM    = 5'd16;
  localparam logic [4:0] S_CR    = 5'd17;
  localparam logic [4:0] S_CW    = 5'd18;
  localparam logic [4:0] S_CDIV  = 5'd19;
  localparam logic [4:0] S_CWAIT = 5'd20;
  localparam logic [4:0] S_CFIN  = 5'd21;
  localparam logic [4:0] S_ERR   = 5'd22;

  function automatic logic signed [W-1:0] mulq_rs(input logic signed [PW-1:0] p);
    logic          neg;
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    neg = p[PW-1];
    m   = neg ? (~p + 1'b1) : p;
    r   = (m + RndBias) >> FracBits;
    if (r > VmaxP) return neg ? Vmin : Vmax;
    if (neg) return -$signed(r[W-1:0]);
    return $signed(r[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SW'(Vmax)) return Vmax;
    if (v < SW'(Vmin)) return Vmin;
    return v[W-1:0];
  endfunction

  logic [4:0]    state_q;
  logic [CW-1:0] i_q, j_q, n_q, ci_q, p_q, ncep_q;
  logic          bank_q, bad_q, ov_q;

  logic signed [W-1:0]  r_mem [MAX_ORDER+1];
  logic signed [W-1:0]  a_mem [2][MAX_ORDER];
  logic signed [W-1:0]  c_mem [MAX_CEP];

  logic signed [MW-1:0] x_q, y_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] acc_q, sum_q;
  logic signed [W-1:0]  e_q, ki_q, aj_q, mq_q;
  logic [CW-1:0]        w_q;
  logic                 neg_q;
  logic [IdxW-1:0]      oidx_q;
  logic signed [W-1:0]  oval_q;
  logic                 obad_q, olast_q;

  logic signed [W-1:0]  ent_value;
  logic                 ent_last;
  logic [CW-1:0]        ent_idx, ent_p, ent_ncep;

  logic                 slot_free, emit, e_nonpos;
  logic [AIW-1:0]       ia, ja, iaj, cia, an_idx;
  logic [RIW-1:0]       ri, rij;
  logic [CIW-1:0]       cnc, cn_idx;
  logic signed [W-1:0]  acc_sat, ki_c, an_c, cn_c;
  logic [W-1:0]         acc_mag;
  logic [SW-1:0]        sum_mag;
  logic signed [SW-1:0] qs, s_c;
  logic signed [CW+W:0] wprod;

  logic           div_start, div_busy;
  logic [DVW-1:0] div_dividend, div_quo;
  logic [W-1:0]   div_divisor;

  assign {ent_value, ent_last, ent_idx, ent_p, ent_ncep} = ent_data_i;

  assign ent_ready_o = (state_q == S_IDLE);
  assign slot_free   = !ov_q || coef_ready_i;
  assign emit        = ((state_q == S_CFIN) || (state_q == S_ERR)) && slot_free;
  assign e_nonpos    = e_q[W-1] || (e_q == '0);

  assign ia     = AIW'(i_q - 1'b1);
  assign ja     = AIW'(j_q - 1'b1);
  assign iaj    = AIW'(i_q - j_q - 1'b1);
  assign cia    = AIW'(ci_q - 1'b1);
  assign an_idx = AIW'(n_q - 1'b1);
  assign ri     = RIW'(i_q);
  assign rij    = RIW'(i_q - j_q);
  assign cnc    = CIW'(n_q - ci_q - 1'b1);
  assign cn_idx = CIW'(n_q - 1'b1);

  assign acc_sat = sat(acc_q);
  assign acc_mag = acc_sat[W-1] ? (~acc_sat + 1'b1) : acc_sat;
  assign sum_mag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;

  assign div_start    = (state_q == S_KDIV) || (state_q == S_CDIV);
  assign div_dividend = (state_q == S_KDIV) ? {acc_mag, {FracBits{1'b0}}}
                                            : {{(DVW-SW){1'b0}}, sum_mag};
  assign div_divisor  = (state_q == S_KDIV) ? e_q : W'(n_q);

  always_comb begin
    if (|div_quo[DVW-1:W-1]) ki_c = neg_q ? Vmin : Vmax;
    else if (neg_q) ki_c = -$signed({1'b0, div_quo[W-2:0]});
    else ki_c = $signed({1'b0, div_quo[W-2:0]});
  end

  assign qs    = neg_q ? -$signed(div_quo[SW-1:0]) : $signed(div_quo[SW-1:0]);
  assign an_c  = (n_q <= p_q) ? a_mem[bank_q][an_idx] : '0;
  assign s_c   = SW'(an_c) + qs;
  assign cn_c  = sat(-s_c);
  assign wprod = $signed({1'b0, w_q}) * mq_q;

  lpcdc_div #(
    .DVW(DVW),
    .DSW(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quo_o     (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      ci_q    <= '0;
      p_q     <= '0;
      ncep_q  <= '0;
      bank_q  <= 1'b0;
      bad_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (coef_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (ent_valid_i && ent_last) begin
            p_q     <= ent_p;
            ncep_q  <= ent_ncep;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          i_q     <= CW'(1);
          bad_q   <= 1'b0;
          bank_q  <= 1'b0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (i_q > p_q) begin
            if (e_nonpos) bad_q <= 1'b1;
            n_q     <= CW'(1);
            ci_q    <= CW'(1);
            state_q <= S_CACC;
          end else if (e_nonpos) begin
            bad_q <= 1'b1;
            i_q   <= i_q + 1'b1;
          end else begin
            j_q     <= CW'(1);
            state_q <= S_ACC;
          end
        end
        S_ACC:   state_q <= (j_q == i_q) ? S_KDIV : S_ACCM;
        S_ACCM:  state_q <= S_ACCA;
        S_ACCA: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_ACC;
        end
        S_KDIV:  state_q <= S_KWAIT;
        S_KWAIT: if (!div_busy) state_q <= S_KKM;
        S_KKM:   state_q <= S_KKA;
        S_KKA:   state_q <= S_EM;
        S_EM:    state_q <= S_EA;
        S_EA: begin
          j_q     <= CW'(1);
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (j_q == i_q) begin
            bank_q  <= ~bank_q;
            i_q     <= i_q + 1'b1;
            state_q <= S_STEP;
          end else begin
            state_q <= S_UPM;
          end
        end
        S_UPM:   state_q <= S_UPA;
        S_UPA: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_UPD;
        end
        S_CACC:  state_q <= ((ci_q == n_q) || (ci_q > p_q)) ? S_CDIV : S_CM;
        S_CM:    state_q <= S_CR;
        S_CR:    state_q <= S_CW;
        S_CW: begin
          ci_q    <= ci_q + 1'b1;
          state_q <= S_CACC;
        end
        S_CDIV:  state_q <= S_CWAIT;
        S_CWAIT: if (!div_busy) state_q <= S_CFIN;
        S_CFIN: begin
          if (slot_free) begin
            if (n_q == ncep_q) begin
              state_q <= S_ERR;
            end else begin
              n_q     <= n_q + 1'b1;
              ci_q    <= CW'(1);
              state_q <= S_CACC;
            end
          end
        end
        S_ERR:   if (slot_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_q * y_q;
    unique case (state_q)
      S_IDLE: if (ent_valid_i) r_mem[RIW'(ent_idx)] <= ent_value;
      S_INIT: e_q <= r_mem[0];
      S_STEP: begin
        if (i_q > p_q) sum_q <= '0;
        else if (e_nonpos) a_mem[bank_q][ia] <= '0;
        else acc_q <= SW'(r_mem[ri]);
      end
      S_ACC: begin
        x_q <= MW'(a_mem[bank_q][ja]);
        y_q <= MW'(r_mem[rij]);
      end
      S_ACCA: acc_q <= acc_q + SW'(mulq_rs(prod_q));
      S_KDIV: neg_q <= acc_q[SW-1];
      S_KWAIT: begin
        ki_q <= ki_c;
        x_q  <= MW'(ki_c);
        y_q  <= MW'(ki_c);
      end
      S_KKA: begin
        x_q <= MW'(e_q);
        y_q <= QOne - MW'(mulq_rs(prod_q));
      end
      S_EA: begin
        e_q <= mulq_rs(prod_q);
        a_mem[~bank_q][ia] <= sat(-SW'(ki_q));
      end
      S_UPD: begin
        x_q  <= MW'(ki_q);
        y_q  <= MW'(a_mem[bank_q][iaj]);
        aj_q <= a_mem[bank_q][ja];
      end
      S_UPA: a_mem[~bank_q][ja] <= sat(SW'(aj_q) - SW'(mulq_rs(prod_q)));
      S_CACC: begin
        x_q <= MW'(a_mem[bank_q][cia]);
        y_q <= MW'(c_mem[cnc]);
      end
      S_CR: begin
        mq_q <= mulq_rs(prod_q);
        w_q  <= n_q - ci_q;
      end
      S_CW:   sum_q <= sum_q + SW'(wprod);
      S_CDIV: neg_q <= sum_q[SW-1];
      S_CFIN: begin
        if (slot_free) begin
          c_mem[cn_idx] <= cn_c;
          sum_q         <= '0;
          oidx_q        <= IdxW'(n_q);
          oval_q        <= cn_c;
          obad_q        <= bad_q;
          olast_q       <= 1'b0;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          oidx_q  <= '0;
          oval_q  <= e_q;
          obad_q  <= bad_q;
          olast_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign coef_valid_o     = ov_q;
  assign coef_index_o     = oidx_q;
  assign coef_value_o     = oval_q;
  assign bad_error_flag_o = obad_q;
  assign frame_last_o     = olast_q;

endmodule

[hw/rtl/lpc_durbin_cepstrum_core.sv]
// lpc_durbin_cepstrum_core: top level of the lpc / cepstrum block
// depends on lpcdc_pkg, lpcdc_front, lpcdc_queue, lpcdc_back
`timescale 1ns / 1ps
// usage:
// lag words r0..rP enter on lag_value_i with lag_valid_i / lag_ready_o, lag 0 first,
// where P is the lpc_order register (index 0); cep_count (index 1) sets N.
// registers are written on the cfg channel, always ready; the user must write them
// only while idle, as the block does not enforce it. per frame the block emits N
// words c1..cN on coef_*_o, then the residual error with coef_index_o = 0 and
// frame_last_o = 1; bad_error_flag_o is the same on every word of a frame.
// a lag word that does not close a frame is taken through a two-entry queue.
// the closing word starts the compute engine, which runs on one shared multiplier,
// a second multiplier for the cepstral weights and one bit-serial divider.
// no lag word is accepted while a frame is being computed and the queue is full.
// reset clears the counters and state and sets both registers to 12.
// a stalled receiver holds the output register and stops the engine.

module lpc_durbin_cepstrum_core import lpcdc_pkg::*; #(
  parameter int MAX_ORDER  = MaxOrderDef,
  parameter int MAX_CEP    = MaxCepDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] lag_value_i,
  input  logic                  lag_valid_i,
  output logic                  lag_ready_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [RegW-1:0]       cfg_data_i,
  output logic                  coef_valid_o,
  input  logic                  coef_ready_i,
  output logic [IdxW-1:0]       coef_index_o,
  output logic [DATA_WIDTH-1:0] coef_value_o,
  output logic                  bad_error_flag_o,
  output logic                  frame_last_o
);

  localparam int CW = cnt_w(MAX_ORDER, MAX_CEP);
  localparam int EW = DATA_WIDTH + 1 + 3 * CW;

  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  lpcdc_front #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_CEP   (MAX_CEP),
    .DATA_WIDTH(DATA_WIDTH),
    .CW        (CW),
    .EW        (EW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lag_value_i (lag_value_i),
    .lag_valid_i (lag_valid_i),
    .lag_ready_o (lag_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  lpcdc_queue #(
    .EW(EW)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_data_i (push_data),
    .wr_ready_o(push_ready),
    .rd_valid_o(pop_valid),
    .rd_data_o (pop_data),
    .rd_ready_i(pop_ready)
  );

  lpcdc_back #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_CEP   (MAX_CEP),
    .DATA_WIDTH(DATA_WIDTH),
    .CW        (CW),
    .EW        (EW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ent_valid_i     (pop_valid),
    .ent_data_i      (pop_data),
    .ent_ready_o     (pop_ready),
    .coef_valid_o    (coef_valid_o),
    .coef_ready_i    (coef_ready_i),
    .coef_index_o    (coef_index_o),
    .coef_value_o    (coef_value_o),
    .bad_error_flag_o(bad_error_flag_o),
    .frame_last_o    (frame_last_o)
  );

endmodule
